@@ hw/rtl/fedl_pkg.sv @@
package fedl_pkg;

    localparam int unsigned DELAY_DEPTH = 262144;
    localparam int unsigned CHANNELS    = 2;

    localparam int unsigned PTR_W     = $clog2(DELAY_DEPTH);
    localparam int unsigned CH_W      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int unsigned MEM_AW    = CH_W + PTR_W;
    localparam int unsigned MEM_DEPTH = 1 << MEM_AW;

    localparam int unsigned SAMPLE_W  = 24;
    localparam int unsigned DELAY_W   = 18;
    localparam int unsigned GAIN_W    = 17;
    localparam int unsigned EN_W      = 2;
    localparam int unsigned CFG_W     = 18;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned DLY_W     = (PTR_W > DELAY_W) ? PTR_W : DELAY_W;

    // tracker: unsigned Q18.32
    localparam int unsigned TRK_W      = 50;
    localparam int unsigned FRAC_W     = 32;
    localparam int unsigned TRACK_STEP = 858993;
    localparam int unsigned SNAP_LIM   = 20;
    localparam logic [TRK_W:0]   SNAP_WIN  = (TRK_W + 1)'(SNAP_LIM) << FRAC_W;
    localparam logic [TRK_W-1:0] TRK_RESET = TRK_W'(1) << FRAC_W;

    // shared multiplier and mix accumulator
    localparam int unsigned MUL_A_W = 35;
    localparam int unsigned MUL_B_W = 25;
    localparam int unsigned MUL_P_W = MUL_A_W + MUL_B_W;
    // full-scale dry and wet terms of the same sign need more than 58 bits
    localparam int unsigned ACC_W   = 60;
    localparam int unsigned GG_W    = 2 * GAIN_W;
    localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1) << (FRAC_W - 1);

    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_DELAY   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DECAY_GAIN     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WET_GAIN       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DRY_GAIN       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_ENABLE = 3'd4;

    localparam logic [DELAY_W-1:0] TARGET_RESET = 18'd2400;
    localparam logic [GAIN_W-1:0]  DECAY_RESET  = 17'd32768;
    localparam logic [GAIN_W-1:0]  UNITY_GAIN   = 17'd65536;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_TRK_DIFF,
        ST_TRK_HI,
        ST_TRK_LO,
        ST_TRK_STEP,
        ST_TRK_SNAP,
        ST_DLY_MOD,
        ST_MIX_DRY,
        ST_MIX_GAIN,
        ST_MIX_WET,
        ST_MIX_SUM,
        ST_MIX_SAT,
        ST_DONE
    } t_state;

endpackage

@@ hw/rtl/feedback_echo_delay_line.sv @@
// channel   signals                                       direction
// in        i_in_valid, o_in_ready, i_sample_in, i_channel  into block
// out       o_out_valid, i_out_ready, o_sample_out, o_clipped out of block
// cfg       i_cfg_we, i_cfg_idx, i_cfg_data                 into block, write only
//
// an enabled item steps through five delay tracker states, a delay modulo state repeated
// once per DELAY_DEPTH subtracted from a delay of DELAY_DEPTH or more, and the mix states,
// products all from one registered 35x25 multiplier; a bypassed item skips to its last step
// the delay store is one single-port-write RAM with registered read; a per-channel fill mark
// makes never-written slots read as zero, so no clearing pass follows reset
// a result waits in the output register while the next item is taken; the block stalls
// in its last step only while that register is still full
module feedback_echo_delay_line
    import fedl_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic signed [SAMPLE_W-1:0] i_sample_in,
    input  logic                       i_channel,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic signed [SAMPLE_W-1:0] o_sample_out,
    output logic                       o_clipped,
    input  logic                       i_cfg_we,
    input  logic [CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [CFG_W-1:0]           i_cfg_data
);

    t_state r_state, n_state;

    logic [DELAY_W-1:0] r_target;
    logic [GAIN_W-1:0]  r_decay, r_wet, r_dry;
    logic [EN_W-1:0]    r_enable;

    logic [PTR_W-1:0]   r_wp [CHANNELS];
    logic               r_full [CHANNELS];
    logic [TRK_W-1:0]   r_tracked;
    logic [DELAY_W-1:0] r_active;

    logic signed [SAMPLE_W-1:0] r_x;
    logic [CH_W-1:0]            r_ch;
    logic                       r_bypass;
    logic [TRK_W-1:0]           r_mag;
    logic                       r_neg;
    logic [TRK_W-1:0]           r_step;
    logic [DLY_W-1:0]           r_dly;
    logic                       r_rd_ok;
    logic signed [SAMPLE_W-1:0] r_delayed;
    logic signed [ACC_W-1:0]    r_acc;
    logic signed [ACC_W-1:0]    r_sum;
    logic signed [SAMPLE_W-1:0] r_y;
    logic                       r_clip;

    logic                       r_out_valid;
    logic signed [SAMPLE_W-1:0] r_out_sample;
    logic                       r_out_clip;

    logic signed [MUL_A_W-1:0] m_a;
    logic signed [MUL_B_W-1:0] m_b;
    logic signed [MUL_P_W-1:0] m_prod;

    logic                    mem_we, mem_re;
    logic [MEM_AW-1:0]       mem_waddr, mem_raddr;
    logic [SAMPLE_W-1:0]     mem_rdata;

    logic                    in_fire, out_free, bypass_in;
    logic [TRK_W-1:0]        goal;
    logic signed [TRK_W:0]   diff;
    logic [TRK_W-1:0]        step_sum;
    logic                    snap;
    logic                    dly_big;
    logic [PTR_W-1:0]        wp_cur, rd_ptr;
    logic [PTR_W:0]          rd_diff;
    logic signed [ACC_W-FRAC_W-1:0] y_full;
    logic                    y_over;
    logic signed [SAMPLE_W-1:0] y_sat;

    fedl_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (m_a),
        .i_b    (m_b),
        .o_prod (m_prod)
    );

    fedl_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (MEM_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (y_sat),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign o_in_ready  = (r_state == ST_IDLE);
    assign in_fire     = i_in_valid && o_in_ready;
    assign out_free    = !r_out_valid || i_out_ready;
    assign bypass_in   = (32'(i_channel) >= CHANNELS) || !r_enable[i_channel];

    assign o_out_valid  = r_out_valid;
    assign o_sample_out = r_out_sample;
    assign o_clipped    = r_out_clip;

    // tracker arithmetic
    assign goal     = {r_target, {FRAC_W{1'b0}}};
    assign diff     = $signed({1'b0, goal}) - $signed({1'b0, r_tracked});
    assign step_sum = r_step + TRK_W'(m_prod[MUL_P_W-2:FRAC_W]);
    assign snap     = (diff < $signed(SNAP_WIN)) && (diff > -$signed(SNAP_WIN));

    // read slot: write pointer minus delay, wrapped into the channel's ring
    assign wp_cur  = r_wp[r_ch];
    assign dly_big = ({1'b0, r_dly} >= (DLY_W + 1)'(DELAY_DEPTH));
    assign rd_diff = {1'b0, wp_cur} - {1'b0, r_dly[PTR_W-1:0]};
    assign rd_ptr  = rd_diff[PTR_W] ? PTR_W'(rd_diff + (PTR_W + 1)'(DELAY_DEPTH))
                                    : rd_diff[PTR_W-1:0];

    assign mem_waddr = {r_ch, wp_cur};
    assign mem_raddr = {r_ch, rd_ptr};

    // rounding and saturation of the mix
    assign y_full = r_sum[ACC_W-1:FRAC_W];
    assign y_over = (y_full[ACC_W-FRAC_W-1:SAMPLE_W-1] != '0) &&
                    (y_full[ACC_W-FRAC_W-1:SAMPLE_W-1] != '1);
    assign y_sat  = y_over ? (y_full[ACC_W-FRAC_W-1] ? SAMPLE_MIN : SAMPLE_MAX)
                           : y_full[SAMPLE_W-1:0];

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    n_state = bypass_in ? ST_DONE : ST_TRK_DIFF;
                end
            end
            ST_TRK_DIFF: n_state = ST_TRK_HI;
            ST_TRK_HI:   n_state = ST_TRK_LO;
            ST_TRK_LO:   n_state = ST_TRK_STEP;
            ST_TRK_STEP: n_state = ST_TRK_SNAP;
            ST_TRK_SNAP: n_state = ST_DLY_MOD;
            ST_DLY_MOD: begin
                if (!dly_big) begin
                    n_state = ST_MIX_DRY;
                end
            end
            ST_MIX_DRY:  n_state = ST_MIX_GAIN;
            ST_MIX_GAIN: n_state = ST_MIX_WET;
            ST_MIX_WET:  n_state = ST_MIX_SUM;
            ST_MIX_SUM:  n_state = ST_MIX_SAT;
            ST_MIX_SAT:  n_state = ST_DONE;
            ST_DONE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        m_a    = '0;
        m_b    = '0;
        mem_we = 1'b0;
        mem_re = 1'b0;
        case (r_state)
            ST_TRK_HI: begin
                m_a = MUL_A_W'(r_mag[TRK_W-1:FRAC_W]);
                m_b = MUL_B_W'(TRACK_STEP);
            end
            ST_TRK_LO: begin
                m_a = MUL_A_W'(r_mag[FRAC_W-1:0]);
                m_b = MUL_B_W'(TRACK_STEP);
            end
            ST_DLY_MOD: begin
                mem_re = !dly_big;
            end
            ST_MIX_DRY: begin
                m_a = MUL_A_W'(r_dry);
                m_b = MUL_B_W'(r_x);
            end
            ST_MIX_GAIN: begin
                m_a = MUL_A_W'(r_decay);
                m_b = MUL_B_W'(r_wet);
            end
            ST_MIX_WET: begin
                m_a = MUL_A_W'(m_prod[GG_W-1:0]);
                m_b = MUL_B_W'(r_delayed);
            end
            ST_MIX_SAT: begin
                mem_we = 1'b1;
            end
            default: begin
                m_a = '0;
            end
        endcase
    end

    // control state, configuration, delay tracker and write pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_target    <= TARGET_RESET;
            r_decay     <= DECAY_RESET;
            r_wet       <= UNITY_GAIN;
            r_dry       <= UNITY_GAIN;
            r_enable    <= '0;
            r_tracked   <= TRK_RESET;
            r_active    <= DELAY_W'(1);
            for (int i = 0; i < CHANNELS; i++) begin
                r_wp[i]   <= '0;
                r_full[i] <= 1'b0;
            end
        end else begin
            r_state <= n_state;
            if (r_state == ST_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_TARGET_DELAY:   r_target <= i_cfg_data[DELAY_W-1:0];
                    CFG_DECAY_GAIN:     r_decay  <= i_cfg_data[GAIN_W-1:0];
                    CFG_WET_GAIN:       r_wet    <= i_cfg_data[GAIN_W-1:0];
                    CFG_DRY_GAIN:       r_dry    <= i_cfg_data[GAIN_W-1:0];
                    CFG_CHANNEL_ENABLE: r_enable <= i_cfg_data[EN_W-1:0];
                    default:            r_enable <= r_enable;
                endcase
            end
            if (r_state == ST_TRK_STEP) begin
                r_tracked <= r_neg ? (r_tracked - step_sum) : (r_tracked + step_sum);
            end
            if (r_state == ST_TRK_SNAP && snap) begin
                r_active <= r_target;
            end
            if (r_state == ST_MIX_SAT) begin
                if (wp_cur == PTR_W'(DELAY_DEPTH - 1)) begin
                    r_wp[r_ch]   <= '0;
                    r_full[r_ch] <= 1'b1;
                end else begin
                    r_wp[r_ch] <= wp_cur + PTR_W'(1);
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    r_x      <= i_sample_in;
                    r_ch     <= CH_W'(i_channel);
                    r_bypass <= bypass_in;
                    r_y      <= i_sample_in;
                    r_clip   <= 1'b0;
                end
            end
            ST_TRK_DIFF: begin
                r_neg <= diff[TRK_W];
                r_mag <= diff[TRK_W] ? TRK_W'(-diff) : TRK_W'(diff);
            end
            ST_TRK_LO: begin
                r_step <= m_prod[TRK_W-1:0];
            end
            ST_TRK_SNAP: begin
                r_dly <= DLY_W'(snap ? r_target : r_active);
            end
            ST_DLY_MOD: begin
                if (dly_big) begin
                    r_dly <= r_dly - DLY_W'(DELAY_DEPTH);
                end else begin
                    // slots past the fill mark were never written and read as zero
                    r_rd_ok <= r_full[r_ch] || (rd_ptr < wp_cur);
                end
            end
            ST_MIX_DRY: begin
                r_delayed <= r_rd_ok ? $signed(mem_rdata) : '0;
            end
            ST_MIX_GAIN: begin
                r_acc <= ACC_W'(m_prod) <<< 16;
            end
            ST_MIX_SUM: begin
                r_sum <= r_acc + ACC_W'(m_prod) + ROUND_HALF;
            end
            ST_MIX_SAT: begin
                r_y    <= y_sat;
                r_clip <= y_over;
            end
            ST_DONE: begin
                if (out_free) begin
                    r_out_sample <= r_y;
                    r_out_clip   <= r_clip && !r_bypass;
                end
            end
            default: begin
                r_bypass <= r_bypass;
            end
        endcase
    end

endmodule

@@ hw/rtl/fedl_ram.sv @@
module fedl_ram #(
    parameter int unsigned WIDTH = 24,
    parameter int unsigned DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ hw/rtl/fedl_mul.sv @@
module fedl_mul
    import fedl_pkg::*;
(
    input  logic                      i_clk,
    input  logic signed [MUL_A_W-1:0] i_a,
    input  logic signed [MUL_B_W-1:0] i_b,
    output logic signed [MUL_P_W-1:0] o_prod
);

    logic signed [MUL_P_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= MUL_P_W'(i_a) * MUL_P_W'(i_b);
    end

    assign o_prod = r_prod;

endmodule
